// ===== hdl/mss_pkg.sv =====
// Shared types and constants for the masked step sequencer.
`default_nettype none

package mss_pkg;

  // Button bank: eight step buttons in bits 0..7, mode button in bit 8.
  localparam int unsigned NumButtons = 9;
  localparam int unsigned StepButtons = 8;
  localparam int unsigned BtnIdxW = 4;
  localparam logic [BtnIdxW-1:0] ModeBit = 4'd8;

  localparam logic [7:0] HoldMax = 8'hFF;
  localparam logic [7:0] DebounceReset = 8'd10;
  localparam logic [StepButtons-1:0] MaskReset = '1;
  localparam logic [NumButtons-1:0] ReleasedLevels = '1;

  // One sample as it arrives on the input channel.
  typedef struct packed {
    logic       clock_level;
    logic       reset_level;
    logic [7:0] step_buttons;
    logic       mode_button;
  } mss_in_t;

  // One result as it leaves on the output channel.
  typedef struct packed {
    logic [2:0] step_select;
    logic [7:0] enabled_steps;
    logic       mode_held;
  } mss_out_t;

  // Outcome of processing one button in the shared unit.
  typedef struct packed {
    logic [7:0]             hold_cnt;
    logic                   take;
    logic [StepButtons-1:0] mask;
    logic                   select;
  } mss_btn_res_t;

endpackage

`default_nettype wire

// ===== hdl/mss_in_if.sv =====
// Input channel interface: one sample per beat.
`default_nettype none

interface mss_in_if;
  import mss_pkg::*;

  logic    valid;
  logic    ready;
  mss_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/mss_out_if.sv =====
// Output channel interface: one result per beat.
`default_nettype none

interface mss_out_if;
  import mss_pkg::*;

  logic     valid;
  logic     ready;
  mss_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/mss_btn_unit.sv =====
// Shared per-button unit: debounce count, level acceptance and press action.
`default_nettype none

module mss_btn_unit (
  input  wire logic [mss_pkg::BtnIdxW-1:0]     idx_i,
  input  wire logic                            lvl_i,
  input  wire logic                            prev_i,
  input  wire logic                            stab_i,
  input  wire logic [7:0]                      count_i,
  input  wire logic [7:0]                      deb_i,
  input  wire logic [mss_pkg::StepButtons-1:0] mask_i,
  input  wire logic                            mode_held_i,
  output mss_pkg::mss_btn_res_t                res_o
);
  import mss_pkg::*;

  logic [7:0]             cnt;
  logic                   take;
  logic                   press;
  logic                   toggle;
  logic [StepButtons-1:0] bit_sel;

  // A raw change restarts the count; otherwise it saturates upward.
  always_comb begin
    if (lvl_i != prev_i) begin
      cnt = '0;
    end else if (count_i == HoldMax) begin
      cnt = HoldMax;
    end else begin
      cnt = count_i + 8'd1;
    end
  end

  // A new level is taken once the count exceeds the debounce setting.
  assign take    = (cnt > deb_i) && (lvl_i != stab_i);
  assign press   = take && (idx_i != ModeBit) && !lvl_i;
  assign bit_sel = StepButtons'(1) << idx_i[2:0];

  // Toggling is refused only when it would clear the last enabled step.
  assign toggle = press && mode_held_i && (mask_i != bit_sel);

  assign res_o.hold_cnt = cnt;
  assign res_o.take     = take;
  assign res_o.mask     = toggle ? (mask_i ^ bit_sel) : mask_i;
  assign res_o.select   = press && !mode_held_i;

endmodule

`default_nettype wire

// ===== hdl/masked_step_sequencer.sv =====
// Masked step sequencer top level: per-sample button scan and step advance.
// Each sample runs from the input beat through the button scan (StBtn), then the
// next-enabled-step search (StSearch) when a clock advance is due, to StFinish.
// One sample at a time: the shared button unit visits one button per cycle,
// and the search steps one position per cycle. Input ready only when idle.
// rst_ni clears step to 0, mask to all ones, debounce setting to 10, buttons
// to released, hold counts to zero and edge detectors to low.
`default_nettype none

module masked_step_sequencer #(
  parameter int unsigned STEP_COUNT = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  mss_in_if.sink          in_i,
  mss_out_if.source       out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_data_i
);
  import mss_pkg::*;

  localparam int unsigned StepW = (STEP_COUNT > 8) ? $clog2(STEP_COUNT) : 3;
  localparam int unsigned KW = $clog2(STEP_COUNT);

  typedef enum logic [1:0] {StIdle, StBtn, StSearch, StFinish} state_e;

  state_e                  state_q;
  logic [7:0]              deb_q;
  logic [StepW-1:0]        step_q;
  logic [StepButtons-1:0]  mask_q;
  logic                    clock_prev_q;
  logic                    reset_prev_q;
  logic [NumButtons-1:0]   raw_prev_q;
  logic [NumButtons-1:0]   stable_q;
  logic [7:0]              hold_q [NumButtons];
  logic [BtnIdxW-1:0]      btn_idx_q;
  logic                    selected_q;
  logic [KW-1:0]           k_q;
  logic                    out_valid_q;
  mss_out_t                out_data_q;

  // Captured sample payload.
  logic [NumButtons-1:0]   raw_q;
  logic                    clk_q;
  logic                    rst_q;
  logic [2:0]              sel_q;

  mss_btn_res_t            btn_res;
  logic [StepW:0]          s_inc;
  logic [StepW-1:0]        s_next;
  logic                    s_enabled;
  logic                    rst_edge;
  logic                    out_free;

  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Shared button unit, fed from the button under the scan index.
  mss_btn_unit u_btn (
    .idx_i       (btn_idx_q),
    .lvl_i       (raw_q[btn_idx_q]),
    .prev_i      (raw_prev_q[btn_idx_q]),
    .stab_i      (stable_q[btn_idx_q]),
    .count_i     (hold_q[btn_idx_q]),
    .deb_i       (deb_q),
    .mask_i      (mask_q),
    .mode_held_i (!stable_q[ModeBit]),
    .res_o       (btn_res)
  );

  // Next step position, wrapping at STEP_COUNT; steps without a mask bit play.
  always_comb begin
    s_inc = {1'b0, step_q} + (StepW+1)'(1);
    if (s_inc >= (StepW+1)'(STEP_COUNT)) begin
      s_next = '0;
    end else begin
      s_next = s_inc[StepW-1:0];
    end
    if ({1'b0, s_next} >= (StepW+1)'(StepButtons)) begin
      s_enabled = 1'b1;
    end else begin
      s_enabled = mask_q[s_next[2:0]];
    end
  end

  assign rst_edge = rst_q && !reset_prev_q;
  assign out_free = !out_valid_q || out_o.ready;

  // Sample capture on an accepted beat, and the selected step button during the scan.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      raw_q <= {in_i.data.mode_button, in_i.data.step_buttons};
      clk_q <= in_i.data.clock_level;
      rst_q <= in_i.data.reset_level;
    end
    if (state_q == StBtn && btn_res.select) begin
      sel_q <= btn_idx_q[2:0];
    end
  end

  // Sequencer: button scan, step search, result hand-off.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      deb_q        <= DebounceReset;
      step_q       <= '0;
      mask_q       <= MaskReset;
      clock_prev_q <= 1'b0;
      reset_prev_q <= 1'b0;
      raw_prev_q   <= ReleasedLevels;
      stable_q     <= ReleasedLevels;
      for (int i = 0; i < NumButtons; i++) begin
        hold_q[i] <= '0;
      end
      btn_idx_q    <= '0;
      selected_q   <= 1'b0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        deb_q <= cfg_data_i;
      end
      // The finishing state sets the valid flag itself when it hands off.
      if (out_valid_q && out_o.ready && state_q != StFinish) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            btn_idx_q  <= '0;
            selected_q <= 1'b0;
            state_q    <= StBtn;
          end
        end

        StBtn: begin
          hold_q[btn_idx_q] <= btn_res.hold_cnt;
          mask_q            <= btn_res.mask;
          if (btn_res.take) begin
            stable_q[btn_idx_q] <= raw_q[btn_idx_q];
          end
          if (btn_res.select) begin
            selected_q <= 1'b1;
          end
          if (btn_idx_q == ModeBit) begin
            // Last button: commit the selection or start the clock advance.
            raw_prev_q <= raw_q;
            if (selected_q) begin
              step_q <= StepW'(sel_q);
            end
            k_q <= '0;
            if (clk_q && !clock_prev_q && !selected_q) begin
              state_q <= StSearch;
            end else begin
              state_q <= StFinish;
            end
          end else begin
            btn_idx_q <= btn_idx_q + BtnIdxW'(1);
          end
        end

        StSearch: begin
          step_q <= s_next;
          k_q    <= k_q + KW'(1);
          if (s_enabled || k_q == KW'(STEP_COUNT - 1)) begin
            state_q <= StFinish;
          end
        end

        StFinish: begin
          if (out_free) begin
            if (rst_edge) begin
              step_q <= '0;
            end
            out_data_q.step_select   <= rst_edge ? 3'd0 : step_q[2:0];
            out_data_q.enabled_steps <= mask_q;
            out_data_q.mode_held     <= !stable_q[ModeBit];
            out_valid_q  <= 1'b1;
            clock_prev_q <= clk_q;
            reset_prev_q <= rst_q;
            state_q      <= StIdle;
          end
        end

        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // The enable mask can never become empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mask_q != '0)
    else $error("enable mask became empty");

  // A taken sample blocks the input until its processing is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready right after accepting a sample");

  // The search never runs past one full lap of the steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSearch) |-> (k_q <= KW'(STEP_COUNT - 1)))
    else $error("step search overran");

  // The button scan index stays within the button bank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBtn) |-> (btn_idx_q <= ModeBit))
    else $error("button scan index out of range");

endmodule

`default_nettype wire
